>>> rtl/sfqd_pkg.sv
`timescale 1ns / 1ps

package sfqd_pkg;

  // Field widths
  localparam int unsigned IDENT_W   = 11;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SEV_W     = 2;
  localparam int unsigned RPM_W     = 14;
  localparam int unsigned TEMP_W    = 12;
  localparam int unsigned OIL_W     = 10;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_IDENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_IDENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;

  localparam logic [IDENT_W-1:0] SENSOR_IDENT_RST = 11'd0;
  localparam logic [IDENT_W-1:0] ERROR_IDENT_RST  = 11'd1;
  localparam logic [TICK_W-1:0]  TIMEOUT_RST      = 32'd100;

  // Default depth of the frame queue
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Frame lengths of the two accepted frame kinds
  localparam logic [LEN_W-1:0] DATA_FRAME_LEN  = 4'd8;
  localparam logic [LEN_W-1:0] ERROR_FRAME_LEN = 4'd1;

  // Range limits of the raw codes
  localparam logic [15:0] RPM_CODE_MAX  = 16'd10000;
  localparam logic [15:0] TEMP_CODE_MAX = 16'd2500;
  localparam logic [15:0] OIL_CODE_MAX  = 16'd1000;
  localparam logic [7:0]  RUN_CODE_MAX  = 8'd1;
  localparam logic signed [TEMP_W:0] TEMP_CODE_OFFSET = 13'sd500;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PARSE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd4;

  // Severity codes
  localparam logic [SEV_W-1:0] SEV_INFO    = 2'd0;
  localparam logic [SEV_W-1:0] SEV_WARNING = 2'd1;
  localparam logic [SEV_W-1:0] SEV_ERROR   = 2'd2;
  localparam logic [SEV_W-1:0] SEV_FATAL   = 2'd3;

  // Command kinds handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_PUSH,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic                   is_err;
    logic [PAYLOAD_W-1:0]   payload;
    logic [TICK_W-1:0]      tick;
  } cmd_t;

  // Command handshake between front and back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SEV_W-1:0]         severity;
    logic [RPM_W-1:0]         rpm_value;
    logic signed [TEMP_W-1:0] temp_tenths;
    logic [OIL_W-1:0]         oil_hundredths;
    logic                     running_flag;
  } rsp_t;

endpackage

>>> rtl/sfqd_intf.sv
`timescale 1ns / 1ps

// Request channel: ingest a frame or read a sensor value.
interface sfqd_req_if import sfqd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [IDENT_W-1:0]   frame_ident;
  logic [LEN_W-1:0]     frame_length;
  logic [PAYLOAD_W-1:0] frame_payload;
  logic [TICK_W-1:0]    tick_now;

  modport source (
    output valid, req_type, frame_ident, frame_length, frame_payload, tick_now,
    input  ready
  );
  modport sink (
    input  valid, req_type, frame_ident, frame_length, frame_payload, tick_now,
    output ready
  );
endinterface

// Result channel: one result for each request.
interface sfqd_rsp_if import sfqd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [SEV_W-1:0]         severity;
  logic [RPM_W-1:0]         rpm_value;
  logic signed [TEMP_W-1:0] temp_tenths;
  logic [OIL_W-1:0]         oil_hundredths;
  logic                     running_flag;

  modport source (
    output valid, status, severity, rpm_value, temp_tenths, oil_hundredths,
           running_flag,
    input  ready
  );
  modport sink (
    input  valid, status, severity, rpm_value, temp_tenths, oil_hundredths,
           running_flag,
    output ready
  );
endinterface

>>> rtl/sfqd_front.sv
`timescale 1ns / 1ps

module sfqd_front import sfqd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sfqd_req_if.sink              req_i,
  output logic [TICK_W-1:0]     timeout_limit_o,
  output cmd_head_t             head_o,
  input  logic                  pop_i
);

  logic [IDENT_W-1:0] sensor_ident_q;
  logic [IDENT_W-1:0] error_ident_q;
  logic [TICK_W-1:0]  timeout_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_ident_q <= SENSOR_IDENT_RST;
      error_ident_q  <= ERROR_IDENT_RST;
      timeout_q      <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SENSOR_IDENT: sensor_ident_q <= cfg_data_i[IDENT_W-1:0];
        CFG_ERROR_IDENT:  error_ident_q  <= cfg_data_i[IDENT_W-1:0];
        CFG_TIMEOUT:      timeout_q      <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign timeout_limit_o = timeout_q;

  // Classify the incoming request into a command for the back end.
  cmd_t cmd_in;
  logic ident_is_data;
  logic ident_is_err;

  always_comb begin
    ident_is_data  = (req_i.frame_ident == sensor_ident_q);
    ident_is_err   = (req_i.frame_ident == error_ident_q);
    cmd_in.is_err  = ident_is_err;
    cmd_in.payload = req_i.frame_payload;
    cmd_in.tick    = req_i.tick_now;
    if (req_i.req_type) begin
      cmd_in.kind = CMD_READ;
    end else if ((ident_is_data && req_i.frame_length == DATA_FRAME_LEN) ||
                 (ident_is_err && req_i.frame_length == ERROR_FRAME_LEN)) begin
      cmd_in.kind = CMD_PUSH;
    end else begin
      cmd_in.kind = CMD_REJECT;
    end
  end

  // Two-entry command queue decoupling intake from execution.
  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign pop         = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = slot_q[rd_q];

endmodule

>>> rtl/sfqd_back.sv
`timescale 1ns / 1ps

module sfqd_back import sfqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TICK_W-1:0] timeout_limit_i,
  input  cmd_head_t         head_i,
  output logic              pop_o,
  sfqd_rsp_if.source        rsp_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_DECODE
  } state_e;

  typedef struct packed {
    logic                 is_err;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TICK_W-1:0]  last_tick_q, last_tick_d;
  logic               have_tick_q, have_tick_d;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  entry_t             mem_q [QUEUE_DEPTH];
  entry_t             mem_rd_q;
  logic               mem_we;
  logic               mem_re;

  logic               out_free;
  logic               late;
  logic [TICK_W-1:0]  elapsed;
  logic [7:0]         xsum;
  logic [15:0]        rpm_code;
  logic [15:0]        temp_code;
  logic [15:0]        oil_code;
  logic [7:0]         run_code;
  logic signed [TEMP_W:0] temp_val;
  rsp_t               rsp_none;

  // Frame store: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= '{is_err: head_i.cmd.is_err, payload: head_i.cmd.payload};
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[rd_ptr_q];
    end
  end

  // Timeout check for a read on an empty queue.
  always_comb begin
    elapsed = head_i.cmd.tick - last_tick_q;
    late    = have_tick_q ? (elapsed > timeout_limit_i) : (head_i.cmd.tick > timeout_limit_i);
  end

  // Field extraction and checksum of the popped frame.
  always_comb begin
    xsum      = mem_rd_q.payload[63:56] ^ mem_rd_q.payload[55:48] ^ mem_rd_q.payload[47:40] ^
                mem_rd_q.payload[39:32] ^ mem_rd_q.payload[31:24] ^ mem_rd_q.payload[23:16] ^
                mem_rd_q.payload[15:8];
    rpm_code  = mem_rd_q.payload[63:48];
    temp_code = mem_rd_q.payload[47:32];
    oil_code  = mem_rd_q.payload[31:16];
    run_code  = mem_rd_q.payload[15:8];
    temp_val  = $signed({1'b0, temp_code[TEMP_W-1:0]}) - TEMP_CODE_OFFSET;
  end

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign pop_o    = (state_q == S_IDLE) && head_i.valid && out_free;

  // Sequencer: executes one command; a read that pops a frame decodes it in S_DECODE.
  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    cnt_d       = cnt_q;
    last_tick_d = last_tick_q;
    have_tick_d = have_tick_q;
    tick_d      = tick_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    rsp_none                = '0;
    rsp_none.status         = ST_INVALID;
    rsp_none.severity       = SEV_ERROR;

    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          rsp_valid_d = 1'b1;
          rsp_d       = rsp_none;
          case (head_i.cmd.kind)
            CMD_PUSH: begin
              if (cnt_q == CNT_FULL) begin
                rsp_d.status = ST_FULL;
              end else begin
                mem_we         = 1'b1;
                wr_ptr_d       = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
                cnt_d          = cnt_q + 1'b1;
                rsp_d.status   = ST_OK;
                rsp_d.severity = SEV_INFO;
              end
            end
            CMD_READ: begin
              if (cnt_q == '0) begin
                rsp_d.status   = late ? ST_TIMEOUT : ST_INVALID;
                rsp_d.severity = late ? SEV_FATAL : SEV_WARNING;
              end else begin
                rsp_valid_d = 1'b0;
                mem_re      = 1'b1;
                rd_ptr_d    = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
                cnt_d       = cnt_q - 1'b1;
                tick_d      = head_i.cmd.tick;
                state_d     = S_DECODE;
              end
            end
            default: ;
          endcase
        end
      end
      S_DECODE: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = rsp_none;
          state_d     = S_IDLE;
          if (mem_rd_q.is_err || xsum != mem_rd_q.payload[7:0]) begin
            rsp_d.status = ST_PARSE;
          end else if (rpm_code > RPM_CODE_MAX || temp_code > TEMP_CODE_MAX ||
                       oil_code > OIL_CODE_MAX || run_code > RUN_CODE_MAX) begin
            rsp_d.status = ST_INVALID;
          end else begin
            rsp_d.status         = ST_OK;
            rsp_d.severity       = SEV_INFO;
            rsp_d.rpm_value      = rpm_code[RPM_W-1:0];
            rsp_d.temp_tenths    = temp_val[TEMP_W-1:0];
            rsp_d.oil_hundredths = oil_code[OIL_W-1:0];
            rsp_d.running_flag   = run_code[0];
            last_tick_d          = tick_q;
            have_tick_d          = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cnt_q       <= '0;
      last_tick_q <= '0;
      have_tick_q <= 1'b0;
      tick_q      <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      cnt_q       <= cnt_d;
      last_tick_q <= last_tick_d;
      have_tick_q <= have_tick_d;
      tick_q      <= tick_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_q.status;
  assign rsp_o.severity       = rsp_q.severity;
  assign rsp_o.rpm_value      = rsp_q.rpm_value;
  assign rsp_o.temp_tenths    = rsp_q.temp_tenths;
  assign rsp_o.oil_hundredths = rsp_q.oil_hundredths;
  assign rsp_o.running_flag   = rsp_q.running_flag;

  // The fill count never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("frame store count above depth");

  // A decode cycle always finds the result register empty.
  a_decode_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECODE |-> !rsp_valid_q)
    else $error("decode started with a pending result");

  // An ingest into a full store is answered as full.
  a_full_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.cmd.kind == CMD_PUSH && cnt_q == CNT_FULL
    |=> rsp_valid_q && rsp_q.status == ST_FULL && $stable(cnt_q))
    else $error("full store not reported");

  // Decoded fields are zero unless the result is ok.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.status != ST_OK |-> rsp_q.rpm_value == '0 &&
    rsp_q.temp_tenths == '0 && rsp_q.oil_hundredths == '0 && !rsp_q.running_flag)
    else $error("nonzero fields on a failed result");

endmodule

>>> rtl/sensor_frame_queue_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req_i    in         req_i.valid/ready    req_type, frame_ident, frame_length,
//                                          frame_payload, tick_now
// rsp_o    out        rsp_o.valid/ready    status, severity, rpm_value,
//                                          temp_tenths, oil_hundredths, running_flag
// cfg      in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// An ingest or a read on an empty store is answered from the idle state; a read that
// pops a frame also enters the decode state, due to the registered store read port.
// The front end takes a request whenever its two-entry command queue has room.
// Reset loads the configuration defaults and clears pointers, fill count and tick
// history, not the frame store. A stalled result holds in the output register.
module sensor_frame_queue_decoder import sfqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sfqd_req_if.sink              req_i,
  sfqd_rsp_if.source            rsp_o
);

  logic [TICK_W-1:0] timeout_limit;
  cmd_head_t         head;
  logic              pop;

  // Intake, configuration and command queue.
  sfqd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .req_i           (req_i),
    .timeout_limit_o (timeout_limit),
    .head_o          (head),
    .pop_i           (pop)
  );

  // Frame store, decode and result register.
  sfqd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .timeout_limit_i (timeout_limit),
    .head_i          (head),
    .pop_o           (pop),
    .rsp_o           (rsp_o)
  );

endmodule
